/* design/mtf_pkg.sv */
// mtf_pkg: constants and shared types for the move-to-front list
// used by mtf_cell and move_to_front_list
`default_nettype none

package mtf_pkg;

    localparam int CAPACITY  = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // insert item accepted this cycle
        logic find;     // find item accepted this cycle
        logic any_hit;  // some cell in the row matched the key
    } mtf_ctrl_t;

endpackage

`default_nettype wire

/* design/mtf_cell.sv */
// mtf_cell: one list position, holds a value and its valid flag
// depends on mtf_pkg; chained by move_to_front_list
`default_nettype none

module mtf_cell
    import mtf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mtf_ctrl_t          ctrl,
    input  wire logic [VALUE_W-1:0] key,
    input  wire logic [VALUE_W-1:0] prev_value,
    input  wire logic               prev_valid,
    input  wire logic               hit_in,
    output logic [VALUE_W-1:0]      value_q,
    output logic                    valid_q,
    output logic                    hit_out
);

    logic [VALUE_W-1:0] value_reg;
    logic               valid_reg;
    logic               match;
    logic               shift;

    assign match   = valid_reg && (value_reg == key);
    assign hit_out = hit_in | match;

    // on a find, every cell up to and including the first match takes its neighbor's entry
    assign shift = ctrl.insert | (ctrl.find & ctrl.any_hit & ~hit_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= prev_value;
        end
    end

    assign value_q = value_reg;
    assign valid_q = valid_reg;

endmodule

`default_nettype wire

/* design/move_to_front_list.sv */
// move_to_front_list: top level, a row of mtf_cell positions plus count and result registers
// depends on mtf_pkg and mtf_cell
`default_nettype none

// Move-to-front list of up to 16 signed 32-bit values. An item is taken at any clock edge
// with start high; busy never rises, so one item can follow another in every cycle. The
// result appears on found, dropped and entry_count in the cycle after the item is taken,
// marked by done high for a single cycle, and must be captured then: there is no way
// to stall it. All cells compare the key at once and the first-match priority ripples
// through the row of cells, so the whole search and shift completes as the item is taken.
module move_to_front_list
    import mtf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               req_type,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic                    found,
    output logic                    dropped,
    output logic [ENTRY_W-1:0]      entry_count
);

    logic                  accept;
    mtf_ctrl_t             ctrl;
    logic [VALUE_W-1:0]    cell_value [CAPACITY];
    logic                  cell_valid [CAPACITY];
    logic                  cell_hit   [CAPACITY];
    logic                  full;

    logic                  done_reg,    done_next;
    logic                  found_reg,   found_next;
    logic                  dropped_reg, dropped_next;
    logic [COUNT_W-1:0]    count_reg,   count_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign ctrl.insert  = accept & (req_type == REQ_INSERT);
    assign ctrl.find    = accept & (req_type == REQ_FIND);
    assign ctrl.any_hit = cell_hit[CAPACITY-1];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_front
                // front cell loads the key itself, which equals the matched value on a find
                mtf_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .key        (value),
                    .prev_value (value),
                    .prev_valid (1'b1),
                    .hit_in     (1'b0),
                    .value_q    (cell_value[i]),
                    .valid_q    (cell_valid[i]),
                    .hit_out    (cell_hit[i])
                );
            end
            else
            begin : g_rest
                mtf_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .key        (value),
                    .prev_value (cell_value[i-1]),
                    .prev_valid (cell_valid[i-1]),
                    .hit_in     (cell_hit[i-1]),
                    .value_q    (cell_value[i]),
                    .valid_q    (cell_valid[i]),
                    .hit_out    (cell_hit[i])
                );
            end
        end
    endgenerate

    assign full = (count_reg == COUNT_W'(CAPACITY));

    always_comb
    begin
        done_next    = accept;
        found_next   = ctrl.find & ctrl.any_hit;
        dropped_next = ctrl.insert & full;
        count_next   = count_reg;
        if (ctrl.insert && !full)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            done_reg    <= done_next;
            found_reg   <= found_next;
            dropped_reg <= dropped_next;
            count_reg   <= count_next;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign dropped     = dropped_reg;
    assign entry_count = ENTRY_W'(count_reg);

endmodule

`default_nettype wire
